>>> hdl/rsvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsvm_pkg
// Shared types, sizes, opcodes and fault codes of the register stack machine.
// ----------------------------------------------------------------------------
package rsvm_pkg;

    // storage sizes
    localparam int MEM_WORDS   = 32768;
    localparam int STACK_DEPTH = 256;
    localparam int AW          = $clog2(MEM_WORDS);
    localparam int SAW         = $clog2(STACK_DEPTH);
    localparam int SLW         = $clog2(STACK_DEPTH + 1);

    // value mask and highest opcode
    localparam logic [14:0] VAL_MASK = 15'h7fff;
    localparam logic [4:0]  OP_LIMIT = 5'h15;

    // opcodes
    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_SET  = 5'd1;
    localparam logic [4:0] OP_PUSH = 5'd2;
    localparam logic [4:0] OP_POP  = 5'd3;
    localparam logic [4:0] OP_EQ   = 5'd4;
    localparam logic [4:0] OP_GT   = 5'd5;
    localparam logic [4:0] OP_JMP  = 5'd6;
    localparam logic [4:0] OP_JT   = 5'd7;
    localparam logic [4:0] OP_JF   = 5'd8;
    localparam logic [4:0] OP_ADD  = 5'd9;
    localparam logic [4:0] OP_MULT = 5'd10;
    localparam logic [4:0] OP_MOD  = 5'd11;
    localparam logic [4:0] OP_AND  = 5'd12;
    localparam logic [4:0] OP_OR   = 5'd13;
    localparam logic [4:0] OP_NOT  = 5'd14;
    localparam logic [4:0] OP_RMEM = 5'd15;
    localparam logic [4:0] OP_WMEM = 5'd16;
    localparam logic [4:0] OP_CALL = 5'd17;
    localparam logic [4:0] OP_RET  = 5'd18;
    localparam logic [4:0] OP_OUT  = 5'd19;
    localparam logic [4:0] OP_IN   = 5'd20;
    localparam logic [4:0] OP_NOOP = 5'd21;

    // fault codes
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_OPC   = 3'd1;
    localparam logic [2:0] FLT_JUMP  = 3'd2;
    localparam logic [2:0] FLT_FULL  = 3'd3;
    localparam logic [2:0] FLT_EMPTY = 3'd4;
    localparam logic [2:0] FLT_MOD   = 3'd5;

    // item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic        action;
        logic [14:0] load_address;
        logic [15:0] load_data;
        logic [7:0]  in_char;
    } req_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_char;
        logic        halted;
        logic [2:0]  fault;
        logic [14:0] pc_now;
    } rsp_t;

    // instruction length in words
    function automatic logic [2:0] op_len(input logic [4:0] op);
        logic [2:0] len;
        begin
            case (op)
                OP_HALT, OP_RET, OP_NOOP:                     len = 3'd1;
                OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT,
                OP_IN:                                        len = 3'd2;
                OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM,
                OP_WMEM:                                      len = 3'd3;
                default:                                      len = 3'd4;
            endcase
            return len;
        end
    endfunction

endpackage

>>> hdl/register_stack_vm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_stack_vm_core
// Fifteen-bit register and stack machine; loads program words and runs one
// instruction per step item, one result per item.
// ----------------------------------------------------------------------------
// A load item writes one word and answers in the cycle after the transfer.
// A step item reads the four words at the program counter one per cycle from
// the word memory, then executes: a memory read adds a read state, and modulo
// runs a bit-serial divider. A bad opcode ends the item once its opcode word
// is read, and a step item on a stopped machine answers without running. One
// item is in work at a time; the result sits in an output register, and a new
// item is taken only once that register is empty or being read out.
// ----------------------------------------------------------------------------
module register_stack_vm_core
    import rsvm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_F0   = 4'd1;
    localparam logic [3:0] S_F1   = 4'd2;
    localparam logic [3:0] S_F2   = 4'd3;
    localparam logic [3:0] S_F3   = 4'd4;
    localparam logic [3:0] S_EXEC = 4'd5;
    localparam logic [3:0] S_RMEM = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;

    // memories
    logic [15:0] mem [MEM_WORDS];
    logic [15:0] stk [STACK_DEPTH];
    logic [15:0] mem_rdata_reg;
    logic [15:0] stk_rdata_reg;

    // control and datapath registers
    logic [3:0]     state_reg, state_next;
    logic [14:0]    pc_reg, pc_next;
    logic           stopped_reg, stopped_next;
    logic [SLW-1:0] level_reg, level_next;
    logic [14:0]    regs_reg [8];
    logic [4:0]     op_reg, op_next;
    logic [15:0]    a_reg, a_next;
    logic [14:0]    va_reg, va_next;
    logic [14:0]    vb_reg, vb_next;
    logic [14:0]    vc_reg, vc_next;
    logic [7:0]     ich_reg, ich_next;
    logic [14:0]    rem_reg, rem_next;
    logic [14:0]    dvd_reg, dvd_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rsp_t           rsp_reg, rsp_next;

    // memory port controls
    logic           mem_re, mem_we, stk_re, stk_we;
    logic [AW-1:0]  mem_raddr, mem_waddr;
    logic [15:0]    mem_wdata, stk_wdata;
    logic [SAW-1:0] stk_raddr, stk_waddr;

    // register write and finish controls
    logic        wb_en;
    logic [14:0] wb_val;
    logic        reg_we;
    logic [2:0]  reg_waddr;
    logic [14:0] reg_wdata;
    logic        fin;
    logic [2:0]  fin_fault;
    logic        fin_ov;
    logic [7:0]  fin_char;
    logic [15:0] fin_tgt;

    logic        accept;
    logic [14:0] rd_value;
    logic [14:0] nxt;
    logic [29:0] prod;
    logic [15:0] div_try;

    assign req_stall = !((state_reg == S_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // operand value of the word just read
    assign rd_value = mem_rdata_reg[15] ? regs_reg[mem_rdata_reg[2:0]]
                                        : mem_rdata_reg[14:0];
    assign nxt  = 15'(AW'(pc_reg[AW-1:0] + AW'(op_len(op_reg))));
    assign prod = vb_reg * vc_reg;
    assign div_try = {rem_reg, dvd_reg[14]};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        stopped_next   = stopped_reg;
        level_next     = level_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        ich_next       = ich_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_re         = 1'b0;
        mem_raddr      = pc_reg[AW-1:0];
        mem_we         = 1'b0;
        mem_waddr      = a_reg[AW-1:0];
        mem_wdata      = 16'h0000;
        stk_re         = 1'b0;
        stk_raddr      = SAW'(level_reg - SLW'(1));
        stk_we         = 1'b0;
        stk_waddr      = level_reg[SAW-1:0];
        stk_wdata      = 16'h0000;
        wb_en          = 1'b0;
        wb_val         = 15'h0000;
        fin            = 1'b0;
        fin_fault      = FLT_NONE;
        fin_ov         = 1'b0;
        fin_char       = 8'h00;
        fin_tgt        = {1'b0, nxt};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ich_next = req.in_char;
                    if (req.action == ACT_LOAD)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = req.load_address[AW-1:0];
                        mem_wdata = req.load_data;
                        fin       = 1'b1;
                        fin_tgt   = {1'b0, pc_reg};
                    end
                    else if (stopped_reg)
                    begin
                        fin     = 1'b1;
                        fin_tgt = {1'b0, pc_reg};
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_F0;
                    end
                end
            end
            S_F0:
            begin
                op_next = mem_rdata_reg[4:0];
                if (mem_rdata_reg > {11'd0, OP_LIMIT})
                begin
                    fin       = 1'b1;
                    fin_fault = FLT_OPC;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(pc_reg[AW-1:0] + AW'(1));
                    state_next = S_F1;
                end
            end
            S_F1:
            begin
                a_next     = mem_rdata_reg;
                va_next    = rd_value;
                mem_re     = 1'b1;
                mem_raddr  = AW'(pc_reg[AW-1:0] + AW'(2));
                state_next = S_F2;
            end
            S_F2:
            begin
                vb_next    = rd_value;
                mem_re     = 1'b1;
                mem_raddr  = AW'(pc_reg[AW-1:0] + AW'(3));
                stk_re     = 1'b1;
                state_next = S_F3;
            end
            S_F3:
            begin
                vc_next    = rd_value;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                fin = 1'b1;
                case (op_reg)
                    OP_HALT:
                    begin
                        stopped_next = 1'b1;
                        fin_tgt      = {1'b0, pc_reg};
                    end
                    OP_SET:
                    begin
                        wb_en  = 1'b1;
                        wb_val = vb_reg;
                    end
                    OP_PUSH:
                    begin
                        if (level_reg >= SLW'(STACK_DEPTH))
                        begin
                            fin_fault = FLT_FULL;
                        end
                        else
                        begin
                            stk_we     = 1'b1;
                            stk_wdata  = {1'b0, va_reg};
                            level_next = level_reg + SLW'(1);
                        end
                    end
                    OP_POP:
                    begin
                        if (level_reg == '0)
                        begin
                            fin_fault = FLT_EMPTY;
                        end
                        else
                        begin
                            wb_en      = 1'b1;
                            wb_val     = stk_rdata_reg[14:0];
                            level_next = level_reg - SLW'(1);
                        end
                    end
                    OP_EQ:
                    begin
                        wb_en  = 1'b1;
                        wb_val = {14'd0, vb_reg == vc_reg};
                    end
                    OP_GT:
                    begin
                        wb_en  = 1'b1;
                        wb_val = {14'd0, vb_reg > vc_reg};
                    end
                    OP_JMP:
                    begin
                        fin_tgt = {1'b0, va_reg};
                    end
                    OP_JT:
                    begin
                        if (va_reg != '0)
                        begin
                            fin_tgt = {1'b0, vb_reg};
                        end
                    end
                    OP_JF:
                    begin
                        if (va_reg == '0)
                        begin
                            fin_tgt = {1'b0, vb_reg};
                        end
                    end
                    OP_ADD:
                    begin
                        wb_en  = 1'b1;
                        wb_val = 15'(vb_reg + vc_reg);
                    end
                    OP_MULT:
                    begin
                        wb_en  = 1'b1;
                        wb_val = prod[14:0];
                    end
                    OP_MOD:
                    begin
                        if (vc_reg == '0)
                        begin
                            fin_fault = FLT_MOD;
                        end
                        else
                        begin
                            fin        = 1'b0;
                            rem_next   = '0;
                            dvd_next   = vb_reg;
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                    end
                    OP_AND:
                    begin
                        wb_en  = 1'b1;
                        wb_val = vb_reg & vc_reg;
                    end
                    OP_OR:
                    begin
                        wb_en  = 1'b1;
                        wb_val = vb_reg | vc_reg;
                    end
                    OP_NOT:
                    begin
                        wb_en  = 1'b1;
                        wb_val = vb_reg ^ VAL_MASK;
                    end
                    OP_RMEM:
                    begin
                        fin        = 1'b0;
                        mem_re     = 1'b1;
                        mem_raddr  = vb_reg[AW-1:0];
                        state_next = S_RMEM;
                    end
                    OP_WMEM:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = va_reg[AW-1:0];
                        mem_wdata = {1'b0, vb_reg};
                    end
                    OP_CALL:
                    begin
                        fin_tgt = {1'b0, va_reg};
                        if ({2'b00, va_reg} >= 17'(MEM_WORDS))
                        begin
                            fin_fault = FLT_JUMP;
                        end
                        else if (level_reg >= SLW'(STACK_DEPTH))
                        begin
                            fin_fault = FLT_FULL;
                        end
                        else
                        begin
                            stk_we     = 1'b1;
                            stk_wdata  = {1'b0, nxt};
                            level_next = level_reg + SLW'(1);
                        end
                    end
                    OP_RET:
                    begin
                        if (level_reg == '0)
                        begin
                            fin_fault = FLT_EMPTY;
                        end
                        else
                        begin
                            fin_tgt    = stk_rdata_reg;
                            level_next = level_reg - SLW'(1);
                        end
                    end
                    OP_OUT:
                    begin
                        fin_ov   = 1'b1;
                        fin_char = va_reg[7:0];
                    end
                    OP_IN:
                    begin
                        wb_en  = 1'b1;
                        wb_val = {7'd0, ich_reg};
                    end
                    default:
                    begin
                    end
                endcase
                // bad target check on any jump
                if ((op_reg == OP_JMP || op_reg == OP_JT || op_reg == OP_JF
                     || op_reg == OP_RET)
                    && fin_fault == FLT_NONE
                    && {1'b0, fin_tgt} >= 17'(MEM_WORDS))
                begin
                    fin_fault  = FLT_JUMP;
                    level_next = level_reg;
                end
            end
            S_RMEM:
            begin
                fin    = 1'b1;
                wb_en  = 1'b1;
                wb_val = mem_rdata_reg[14:0];
            end
            S_DIV:
            begin
                // one restoring divide step per cycle
                if (div_try >= {1'b0, vc_reg})
                begin
                    rem_next = 15'(div_try - {1'b0, vc_reg});
                end
                else
                begin
                    rem_next = div_try[14:0];
                end
                dvd_next = {dvd_reg[13:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd14)
                begin
                    fin    = 1'b1;
                    wb_en  = 1'b1;
                    wb_val = rem_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // store to memory when the destination is a literal
        if (wb_en && !a_reg[15])
        begin
            mem_we    = 1'b1;
            mem_waddr = a_reg[AW-1:0];
            mem_wdata = {1'b0, wb_val};
        end

        // finish the item and load the result register
        if (fin)
        begin
            state_next = S_IDLE;
            if (fin_fault != FLT_NONE)
            begin
                stopped_next = 1'b1;
                mem_we       = 1'b0;
                stk_we       = 1'b0;
            end
            else
            begin
                pc_next = fin_tgt[14:0];
            end
            rsp_valid_next     = 1'b1;
            rsp_next.out_valid = fin_ov;
            rsp_next.out_char  = fin_char;
            rsp_next.halted    = stopped_next;
            rsp_next.fault     = fin_fault;
            rsp_next.pc_now    = pc_next;
        end
    end

    assign reg_we    = wb_en && a_reg[15];
    assign reg_waddr = a_reg[2:0];
    assign reg_wdata = wb_val;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            level_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            stopped_reg   <= stopped_next;
            level_reg     <= level_next;
            rsp_valid_reg <= rsp_valid_next;
            if (reg_we)
            begin
                regs_reg[reg_waddr] <= reg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        va_reg  <= va_next;
        vb_reg  <= vb_next;
        vc_reg  <= vc_next;
        ich_reg <= ich_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        cnt_reg <= cnt_next;
        rsp_reg <= rsp_next;
    end

    // word memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stk[stk_raddr];
        end
    end

    // stack level stays within its depth
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= SLW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    // only reset restarts a stopped machine
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("machine restarted");

    // a stopped machine keeps its program counter
    a_pc: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> $stable(pc_reg))
        else $error("pc moved while stopped");

    // a fault result always reports the machine halted
    a_flt: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.fault != FLT_NONE) |-> rsp_reg.halted)
        else $error("fault without halt");

endmodule
